// ----- src/palette_color_crossfade_defines.svh -----
// assertion macros shared by the palette color crossfade modules
`ifndef PALETTE_COLOR_CROSSFADE_DEFINES_SVH
`define PALETTE_COLOR_CROSSFADE_DEFINES_SVH

// condition a implies condition b in the same cycle
`define PCF_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("pcf check failed");

// condition a implies condition b, checked after the delay given by the argument n
`define PCF_ASSERT_LAT(label, clk, rst_n, a, n, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##n (b)) \
		else $error("pcf latency check failed");

`endif

// ----- src/pcf_pkg.sv -----
// shared widths, register indexes and types of the palette color crossfade
package pcf_pkg;

	localparam int TICK_W          = 32;
	localparam int STEPS_W         = 16;
	localparam int CHAN_W          = 8;
	localparam int NUM_CHAN        = 3;
	localparam int COLOR_W         = NUM_CHAN * CHAN_W;
	localparam int NUM_W           = CHAN_W + STEPS_W;
	localparam int ENTRY_REGS      = 4;
	localparam int SIZE_W          = 3;
	// holds a color count up to the largest palette of eight
	localparam int COUNT_W         = 4;
	localparam int CFG_ADDR_W      = 3;
	localparam int CFG_DATA_W      = COLOR_W;
	localparam int MAX_PALETTE_DEF = 4;
	// fetch, multiply, then one quotient bit per stage
	localparam int BLEND_LAT       = 2 + CHAN_W;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_PALETTE_SIZE = 3'd0,
		REG_STEPS        = 3'd1,
		REG_ENTRY_0      = 3'd2,
		REG_ENTRY_1      = 3'd3,
		REG_ENTRY_2      = 3'd4,
		REG_ENTRY_3      = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [STEPS_W-1:0] steps;
	} cfg_t;

endpackage

// ----- src/pcf_cfg.sv -----
// configuration registers with clamping of color count and step count
module pcf_cfg import pcf_pkg::*; #(
	parameter int MAX_PALETTE = MAX_PALETTE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg,
	output logic [COLOR_W-1:0]    palette [MAX_PALETTE]
);

	localparam int NREG = (MAX_PALETTE < ENTRY_REGS) ? MAX_PALETTE : ENTRY_REGS;

	cfg_t               cfg_q;
	logic [COLOR_W-1:0] palette_q [NREG];
	logic [COUNT_W-1:0] size_wr;
	logic [STEPS_W-1:0] steps_wr;

	always_comb begin
		size_wr = COUNT_W'(cfg_data[SIZE_W-1:0]);
		if (size_wr == '0) begin
			size_wr = COUNT_W'(1);
		end else if (size_wr > COUNT_W'(MAX_PALETTE)) begin
			size_wr = COUNT_W'(MAX_PALETTE);
		end
		steps_wr = cfg_data[STEPS_W-1:0];
		if (steps_wr == '0) begin
			steps_wr = STEPS_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.count <= COUNT_W'(1);
			cfg_q.steps <= STEPS_W'(1);
			for (int i = 0; i < NREG; i++) begin
				palette_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_PALETTE_SIZE: begin
					cfg_q.count <= size_wr;
				end
				REG_STEPS: begin
					cfg_q.steps <= steps_wr;
				end
				default: begin
					for (int i = 0; i < NREG; i++) begin
						if (cfg_addr == CFG_ADDR_W'(int'(REG_ENTRY_0) + i)) begin
							palette_q[i] <= cfg_data;
						end
					end
				end
			endcase
		end
	end

	assign cfg = cfg_q;

	// slots without a register read as black
	for (genvar i = 0; i < MAX_PALETTE; i++) begin : g_slot
		if (i < NREG) begin : g_reg
			assign palette[i] = palette_q[i];
		end else begin : g_black
			assign palette[i] = '0;
		end
	end

endmodule

// ----- src/pcf_phase.sv -----
// pipelined tick modulo and palette index split, one bit per stage
`include "palette_color_crossfade_defines.svh"
module pcf_phase import pcf_pkg::*; #(
	parameter int MAX_PALETTE = MAX_PALETTE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cfg_t                           cfg,
	input  logic                           in_vld,
	input  logic [TICK_W-1:0]              in_tick,
	output logic                           out_vld,
	output logic [$clog2(MAX_PALETTE)-1:0] out_idx,
	output logic [STEPS_W-1:0]             out_sub
);

	localparam int CNT_W = $clog2(MAX_PALETTE + 1);
	localparam int IDX_W = $clog2(MAX_PALETTE);
	localparam int MW    = STEPS_W + CNT_W;

	logic [MW-1:0] modulus;
	assign modulus = MW'(cfg.count[CNT_W-1:0]) * MW'(cfg.steps);

	logic              mod_vld_s  [TICK_W];
	logic [MW-1:0]     mod_rem_s  [TICK_W];
	logic [TICK_W-1:0] mod_tick_s [TICK_W-1];

	// restoring remainder, tick bits enter msb first
	for (genvar k = 0; k < TICK_W; k++) begin : g_mod
		logic              vld_in;
		logic [MW-1:0]     rem_in;
		logic [TICK_W-1:0] tick_in;
		logic [MW:0]       trial;
		logic [MW:0]       diff;

		if (k == 0) begin : g_first
			assign vld_in  = in_vld;
			assign rem_in  = '0;
			assign tick_in = in_tick;
		end else begin : g_next
			assign vld_in  = mod_vld_s[k-1];
			assign rem_in  = mod_rem_s[k-1];
			assign tick_in = mod_tick_s[k-1];
		end

		assign trial = {rem_in, tick_in[TICK_W-1]};
		assign diff  = trial - {1'b0, modulus};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				mod_vld_s[k] <= 1'b0;
			end else begin
				mod_vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			mod_rem_s[k] <= (trial >= {1'b0, modulus}) ? diff[MW-1:0] : trial[MW-1:0];
		end

		if (k < TICK_W - 1) begin : g_shift
			always_ff @(posedge clk) begin
				mod_tick_s[k] <= {tick_in[TICK_W-2:0], 1'b0};
			end
		end
	end

	logic             sel_vld_s [IDX_W];
	logic [MW-1:0]    sel_rem_s [IDX_W];
	logic [IDX_W-1:0] sel_idx_s [IDX_W];

	// phase over steps, quotient is the source color
	for (genvar j = 0; j < IDX_W; j++) begin : g_sel
		localparam int B = IDX_W - 1 - j;
		logic             vld_in;
		logic [MW-1:0]    rem_in;
		logic [IDX_W-1:0] idx_in;
		logic [MW-1:0]    divisor;
		logic             ge;

		if (j == 0) begin : g_first
			assign vld_in = mod_vld_s[TICK_W-1];
			assign rem_in = mod_rem_s[TICK_W-1];
			assign idx_in = '0;
		end else begin : g_next
			assign vld_in = sel_vld_s[j-1];
			assign rem_in = sel_rem_s[j-1];
			assign idx_in = sel_idx_s[j-1];
		end

		assign divisor = MW'(cfg.steps) << B;
		assign ge      = rem_in >= divisor;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sel_vld_s[j] <= 1'b0;
			end else begin
				sel_vld_s[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			sel_rem_s[j] <= ge ? (rem_in - divisor) : rem_in;
			sel_idx_s[j] <= idx_in | (IDX_W'(ge) << B);
		end
	end

	assign out_vld = sel_vld_s[IDX_W-1];
	assign out_idx = sel_idx_s[IDX_W-1];
	assign out_sub = sel_rem_s[IDX_W-1][STEPS_W-1:0];

	`PCF_ASSERT_IMP(a_phase_range, clk, arst_n, out_vld, (sel_rem_s[IDX_W-1] < MW'(cfg.steps)) && (COUNT_W'(out_idx) < cfg.count))

endmodule

// ----- src/pcf_blend.sv -----
// color fetch, weighted channel sums and pipelined divide by the step count
`include "palette_color_crossfade_defines.svh"
module pcf_blend import pcf_pkg::*; #(
	parameter int MAX_PALETTE = MAX_PALETTE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cfg_t                           cfg,
	input  logic [COLOR_W-1:0]             palette [MAX_PALETTE],
	input  logic                           in_vld,
	input  logic [$clog2(MAX_PALETTE)-1:0] in_idx,
	input  logic [STEPS_W-1:0]             in_sub,
	output logic                           out_vld,
	output logic [COLOR_W-1:0]             out_color
);

	localparam int IDX_W = $clog2(MAX_PALETTE);

	logic [COUNT_W-1:0] nxt;
	logic [IDX_W-1:0]   dst_idx;

	assign nxt     = COUNT_W'(in_idx) + COUNT_W'(1);
	assign dst_idx = (nxt >= cfg.count) ? '0 : nxt[IDX_W-1:0];

	logic               fch_vld_s1;
	logic [COLOR_W-1:0] src_s1;
	logic [COLOR_W-1:0] dst_s1;
	logic [STEPS_W-1:0] sub_s1;
	logic [STEPS_W-1:0] rest_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fch_vld_s1 <= 1'b0;
		end else begin
			fch_vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		src_s1  <= palette[in_idx];
		dst_s1  <= palette[dst_idx];
		sub_s1  <= in_sub;
		rest_s1 <= cfg.steps - in_sub;
	end

	// src * (steps - sub) + dst * sub, the floor of this over steps is the level
	logic             mul_vld_s2;
	logic [NUM_W-1:0] num_s2 [NUM_CHAN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_vld_s2 <= 1'b0;
		end else begin
			mul_vld_s2 <= fch_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < NUM_CHAN; c++) begin
			num_s2[c] <= NUM_W'(src_s1[c*CHAN_W +: CHAN_W]) * NUM_W'(rest_s1)
				+ NUM_W'(dst_s1[c*CHAN_W +: CHAN_W]) * NUM_W'(sub_s1);
		end
	end

	logic              div_vld_s [CHAN_W];
	logic [NUM_W-1:0]  div_n_s   [CHAN_W][NUM_CHAN];
	logic [CHAN_W-1:0] div_q_s   [CHAN_W][NUM_CHAN];

	for (genvar j = 0; j < CHAN_W; j++) begin : g_div
		localparam int B = CHAN_W - 1 - j;
		logic             vld_in;
		logic [NUM_W-1:0] divisor;

		assign divisor = NUM_W'(cfg.steps) << B;

		if (j == 0) begin : g_first
			assign vld_in = mul_vld_s2;
		end else begin : g_next
			assign vld_in = div_vld_s[j-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[j] <= 1'b0;
			end else begin
				div_vld_s[j] <= vld_in;
			end
		end

		for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
			logic [NUM_W-1:0]  n_in;
			logic [CHAN_W-1:0] q_in;
			logic              ge;

			if (j == 0) begin : g_first
				assign n_in = num_s2[c];
				assign q_in = '0;
			end else begin : g_next
				assign n_in = div_n_s[j-1][c];
				assign q_in = div_q_s[j-1][c];
			end

			assign ge = n_in >= divisor;

			always_ff @(posedge clk) begin
				div_n_s[j][c] <= ge ? (n_in - divisor) : n_in;
				div_q_s[j][c] <= q_in | (CHAN_W'(ge) << B);
			end
		end
	end

	assign out_vld = div_vld_s[CHAN_W-1];
	for (genvar c = 0; c < NUM_CHAN; c++) begin : g_out
		assign out_color[c*CHAN_W +: CHAN_W] = div_q_s[CHAN_W-1][c];
	end

	`PCF_ASSERT_IMP(a_div_rem, clk, arst_n, out_vld, (div_n_s[CHAN_W-1][0] < NUM_W'(cfg.steps)) && (div_n_s[CHAN_W-1][1] < NUM_W'(cfg.steps)) && (div_n_s[CHAN_W-1][2] < NUM_W'(cfg.steps)))

endmodule

// ----- src/palette_color_crossfade.sv -----
// top level of the palette color crossfade
// A tick word goes in on any cycle that start is high and busy is low; busy
// never rises, so one tick may enter every clock. Each tick gives one RGB word,
// shown for a single cycle with done high. The receiver cannot hold a word
// off, and none is ever dropped. The word passes through the restoring
// divider pipelines: one stage for each tick bit to take the tick modulo
// (colors * steps), one stage for each bit of the palette index, then a fetch
// stage, a multiply stage and one stage per bit of each 8-bit level. Register
// writes (palette size, steps per color, four colors) take effect at once and
// are meant for when no word is in flight.
`include "palette_color_crossfade_defines.svh"
module palette_color_crossfade import pcf_pkg::*; #(
	parameter int MAX_PALETTE = MAX_PALETTE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// tick word in
	input  logic                  start,
	output logic                  busy,
	input  logic [TICK_W-1:0]     tick_count,
	// register writes
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// color word out
	output logic                  done,
	output logic [CHAN_W-1:0]     red_level,
	output logic [CHAN_W-1:0]     green_level,
	output logic [CHAN_W-1:0]     blue_level
);

	localparam int IDX_W = $clog2(MAX_PALETTE);
	localparam int LAT   = TICK_W + IDX_W + BLEND_LAT;

	cfg_t               cfg;
	logic [COLOR_W-1:0] palette [MAX_PALETTE];
	logic               ph_vld;
	logic [IDX_W-1:0]   ph_idx;
	logic [STEPS_W-1:0] ph_sub;
	logic [COLOR_W-1:0] color;

	// fully pipelined, nothing ever holds the input off
	assign busy = 1'b0;

	pcf_cfg #(.MAX_PALETTE(MAX_PALETTE)) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.cfg      (cfg),
		.palette  (palette)
	);

	// tick modulo the cycle length, then split into source index and sub step
	pcf_phase #(.MAX_PALETTE(MAX_PALETTE)) u_phase (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.in_vld  (start && !busy),
		.in_tick (tick_count),
		.out_vld (ph_vld),
		.out_idx (ph_idx),
		.out_sub (ph_sub)
	);

	// linear blend toward the next color, floored per channel
	pcf_blend #(.MAX_PALETTE(MAX_PALETTE)) u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.palette   (palette),
		.in_vld    (ph_vld),
		.in_idx    (ph_idx),
		.in_sub    (ph_sub),
		.out_vld   (done),
		.out_color (color)
	);

	// red in the top byte, blue in the bottom byte
	assign red_level   = color[2*CHAN_W +: CHAN_W];
	assign green_level = color[CHAN_W +: CHAN_W];
	assign blue_level  = color[0 +: CHAN_W];

	`PCF_ASSERT_LAT(a_word_latency, clk, arst_n, start && !busy, LAT, done)

endmodule
